>>> rtl/sieve_prime_root_setup_assert.svh
// assertion macros for the sieve prime root setup block
`ifndef SIEVE_PRIME_ROOT_SETUP_ASSERT_SVH
`define SIEVE_PRIME_ROOT_SETUP_ASSERT_SVH

// same-cycle implication, checked on clk, off while reset is held
`define SPRS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off while reset is held
`define SPRS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sprs_pkg.sv
// constants and types for the sieve prime root setup block
`default_nettype none
package sprs_pkg;
	localparam int PRIME_BITS_DEF = 32;
	localparam int FIELD_W = 32;
	localparam int LIMIT_W = 64;
	localparam int CFG_W = 64;
	localparam int IN_TDATA_W = 32;
	localparam int OUT_TDATA_W = 72;
	localparam int CNT_W = 6;

	localparam logic [31:0] PROD_N_RST = 32'd210;

	// register indexes of the configuration port
	localparam logic REG_PROD_N = 1'b0;
	localparam logic REG_LOW_LIMIT = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_OFFS = 7'b0000010,
		ST_PMOD = 7'b0000100,
		ST_CHECK = 7'b0001000,
		ST_DIV = 7'b0010000,
		ST_FIN = 7'b0100000,
		ST_HOLD = 7'b1000000
	} state_t;
endpackage
`default_nettype wire

>>> rtl/sieve_prime_root_setup.sv
// Per-prime sieve setup: for each prime p, root = p - inverse(prod_n) mod p by the extended
// Euclidean algorithm, start_offset = (low_limit + 1) mod p, and no_inverse when prod_n has
// no inverse mod p (root is then 0). All arithmetic goes through one restoring divide step
// (compare, subtract, shift) that handles one quotient bit per cycle, with a signed
// multiply-accumulate of the quotient folded in by Horner steps. An item runs through the
// offset reduction of low_limit + 1, the reduction of prod_n mod p, then a check and a
// division for each Euclid step (at most about 1.44 * PRIME_BITS of them), and a final
// state; primes 0 and 1 go straight to the final state. A finished item waits there until
// the output register drains. The input is not ready while an item is at work.
// A finished result sits in an output register while the next item is taken.
`default_nettype none
`include "sieve_prime_root_setup_assert.svh"
module sieve_prime_root_setup
	import sprs_pkg::*;
#(
	parameter int PRIME_BITS = PRIME_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [CFG_W-1:0] cfg_wdata,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [IN_TDATA_W-1:0] s_tdata, // [31:0] prime
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata // [31:0] root, [63:32] start_offset, [64] no_inverse
);
	localparam int TW = PRIME_BITS + 2;

	state_t state_q;
	logic [FIELD_W-1:0] prod_n_q;
	logic [LIMIT_W-1:0] low_limit_q;
	logic [PRIME_BITS-1:0] p_q, r0_q, r1_q, rem_q, start_q;
	logic [LIMIT_W-1:0] num_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [TW-1:0] t0_q, t1_q, tacc_q;
	logic out_valid_q, out_flag_q;
	logic [FIELD_W-1:0] out_root_q, out_start_q;

	logic [PRIME_BITS-1:0] divisor, rem_nx, p_in;
	logic [PRIME_BITS:0] rem_sh;
	logic take, last, out_free, no_inv;
	logic signed [TW-1:0] tacc_nx, root_w;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_n_q <= PROD_N_RST;
			low_limit_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROD_N: prod_n_q <= cfg_wdata[FIELD_W-1:0];
				REG_LOW_LIMIT: low_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign p_in = s_tdata[PRIME_BITS-1:0];
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_tready;

	// shared divide step: one quotient bit per cycle
	always_comb begin
		divisor = (state_q == ST_DIV) ? r1_q : p_q;
		rem_sh = {rem_q, num_q[LIMIT_W-1]};
		take = rem_sh >= {1'b0, divisor};
		rem_nx = take ? PRIME_BITS'(rem_sh - {1'b0, divisor}) : rem_sh[PRIME_BITS-1:0];
		tacc_nx = (tacc_q <<< 1) + (take ? t1_q : TW'(0));
		last = (cnt_q == '0);
	end

	// final root from the Bezout coefficient left in t0
	always_comb begin
		no_inv = (r0_q != PRIME_BITS'(1));
		if (t0_q[TW-1]) begin
			root_w = -t0_q;
		end else begin
			root_w = $signed({2'b00, p_q}) - t0_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= (p_in < PRIME_BITS'(2)) ? ST_FIN : ST_OFFS;
					end
				end
				ST_OFFS: begin
					if (last) begin
						state_q <= ST_PMOD;
					end
				end
				ST_PMOD: begin
					if (last) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= (r1_q == '0) ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					if (last) begin
						state_q <= ST_CHECK;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_HOLD: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				p_q <= p_in;
				num_q <= low_limit_q + LIMIT_W'(1);
				rem_q <= '0;
				cnt_q <= CNT_W'(LIMIT_W - 1);
				// degenerate prime: r0 of zero forces no_inverse
				r0_q <= '0;
				start_q <= '0;
				t0_q <= '0;
			end
			ST_OFFS: begin
				if (last) begin
					start_q <= rem_nx;
					num_q <= {prod_n_q, (LIMIT_W - FIELD_W)'(0)};
					rem_q <= '0;
					cnt_q <= CNT_W'(FIELD_W - 1);
				end else begin
					num_q <= num_q << 1;
					rem_q <= rem_nx;
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			ST_PMOD: begin
				num_q <= num_q << 1;
				rem_q <= rem_nx;
				cnt_q <= cnt_q - CNT_W'(1);
				if (last) begin
					r0_q <= p_q;
					r1_q <= rem_nx;
					t0_q <= '0;
					t1_q <= TW'(1);
				end
			end
			ST_CHECK: begin
				num_q <= {r0_q, (LIMIT_W - PRIME_BITS)'(0)};
				rem_q <= '0;
				tacc_q <= '0;
				cnt_q <= CNT_W'(PRIME_BITS - 1);
			end
			ST_DIV: begin
				num_q <= num_q << 1;
				rem_q <= rem_nx;
				tacc_q <= tacc_nx;
				cnt_q <= cnt_q - CNT_W'(1);
				if (last) begin
					r0_q <= r1_q;
					r1_q <= rem_nx;
					t0_q <= t1_q;
					t1_q <= t0_q - tacc_nx;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_flag_q <= no_inv;
					out_root_q <= no_inv ? '0 : FIELD_W'(root_w[PRIME_BITS-1:0]);
					out_start_q <= FIELD_W'(start_q);
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {(OUT_TDATA_W - 2 * FIELD_W - 1)'(0), out_flag_q, out_start_q, out_root_q};

	`SPRS_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
		"input still ready after an item was taken")
	`SPRS_ASSERT_IMP(a_div_nonzero, state_q == ST_DIV, r1_q != '0,
		"euclid division by zero")
	`SPRS_ASSERT_IMP(a_rem_below_div,
		state_q == ST_OFFS || state_q == ST_PMOD || state_q == ST_DIV, rem_q < divisor,
		"partial remainder not below divisor")
	`SPRS_ASSERT_NXT(a_result_posted, state_q == ST_FIN && out_free, m_tvalid,
		"finished item not posted to the output")
endmodule
`default_nettype wire
